// ----- hdl/sdsp_pkg.sv -----
// Shared types, constants and character helpers for the signed decimal sum parser.
// No dependencies; compile this file first.
package sdsp_pkg;

  // Parser phase codes. Code 3 is unused and behaves like PH_SKIP.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // One result item as it travels from the parser core to the output queue.
  typedef struct packed {
    logic signed [31:0] value;
    logic               bad_format;
    logic               last_of_run;
  } sdsp_result_t;

  // ASCII codes used by the parser.
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Output queue geometry: one byte can cause two results.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // Whitespace is space and the control codes from tab through carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- hdl/sdsp_text_if.sv -----
// Input channel carrying one ASCII text byte per item.
// Depends on nothing.
interface sdsp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- hdl/sdsp_result_if.sv -----
// Output channel carrying one parsed result item.
// Depends on nothing.
interface sdsp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               bad_format;
  logic               last_of_run;

  modport source (output valid, output value, output bad_format, output last_of_run,
                  input ready);
  modport sink   (input valid, input value, input bad_format, input last_of_run,
                  output ready);
endinterface

// ----- hdl/signed_decimal_sum_parser.sv -----
// Top level of the signed decimal sum parser: parser core plus output queue.
// Depends on sdsp_pkg, sdsp_text_if, sdsp_result_if and sdsp_core.
//
// Usage:
//   The text channel takes one ASCII byte per item; the result channel gives
//   one parsed sum per item, with bad_format for a missing digit and
//   last_of_run on the final result caused by a byte.
//   Each accepted byte updates the parser in the same cycle; its results enter
//   a four-entry output queue and are visible on the result channel from the
//   next cycle. Throughput is one byte per cycle while the text channel is
//   ready; the parser update is one shift-add for the digit and one add for
//   the sum. A byte that ends a number and also starts a bad token gives two
//   results, which leave on the result channel one after another.
//   The text channel is ready while at most two results wait in the queue,
//   so a stalled receiver holds results in the queue and then stops input
//   after at most four results are pending. Nothing is dropped.
//   Reset (synchronous, active high) empties the queue and returns the parser
//   to skipping whitespace with a zero term and zero sum.
module signed_decimal_sum_parser (
  input  logic                 clk,
  input  logic                 rst,
  sdsp_text_if.sink            text,
  sdsp_result_if.source        result
);
  import sdsp_pkg::*;

  logic                 fire;
  logic                 pop;
  logic [1:0]           res_count;
  sdsp_result_t         res0, res1;
  sdsp_result_t         queue [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [OUTQ_CW-1:0]   count;
  logic [1:0]           push_n;

  // Input handshake: room for the two results one byte can cause.
  assign text.ready = (count <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign fire       = text.valid && text.ready;
  assign push_n     = fire ? res_count : 2'd0;

  sdsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .text_byte (text.text_byte),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + OUTQ_AW'(1)] <= res1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      count <= count + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
    end
  end

  // Result channel driven from the head of the queue.
  assign result.valid       = (count != '0);
  assign pop                = result.valid && result.ready;
  assign result.value       = queue[rd_ptr].value;
  assign result.bad_format  = queue[rd_ptr].bad_format;
  assign result.last_of_run = queue[rd_ptr].last_of_run;

`ifndef SYNTHESIS
  // The queue never holds more items than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("output queue overfilled");

  // When a byte gives two results, only the second closes the run.
  a_two_results_last: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (!res0.last_of_run && res1.last_of_run))
    else $error("last_of_run misplaced on a two-result byte");

  // An error result always carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.bad_format) |-> (result.value == 32'sd0))
    else $error("error result with nonzero value");

  // A result accepted on a full queue frees one entry; input ready still follows the fill count.
  a_full_drain: assert property (@(posedge clk) disable iff (rst)
    (count == OUTQ_CW'(OUTQ_DEPTH) && pop) |=> text.ready == (count <= OUTQ_CW'(2)))
    else $error("input ready inconsistent after draining a full queue");
`endif

endmodule

// ----- hdl/sdsp_core.sv -----
// Parser state registers and the per-byte update, giving up to two results per byte.
// Depends on sdsp_pkg.
module sdsp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           text_byte,
  output logic [1:0]           res_count,
  output sdsp_pkg::sdsp_result_t res0,
  output sdsp_pkg::sdsp_result_t res1
);
  import sdsp_pkg::*;

  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] term, term_next;
  logic [31:0] running_sum, running_sum_next;

  logic        c_ws, c_dig, c_sign, c_bar;
  logic [31:0] digit;
  logic [31:0] signed_term;
  logic [31:0] term_x10;

  // Byte classification.
  assign c_ws   = is_ws(text_byte);
  assign c_dig  = is_dig(text_byte);
  assign c_sign = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
  assign c_bar  = (text_byte == CH_BAR);
  assign digit  = {28'd0, text_byte[3:0]};

  // Term arithmetic: times ten as two shifts and an add.
  assign signed_term = negative ? (32'd0 - term) : term;
  assign term_x10    = {term[28:0], 3'b000} + {term[30:0], 1'b0};

  // Next state and results for the byte on the input.
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    term_next        = term;
    running_sum_next = running_sum;
    res_count        = 2'd0;
    res0             = '0;
    res1             = '0;
    unique case (phase)
      PH_SIGNED: begin
        if (c_dig) begin
          term_next  = digit;
          phase_next = PH_DIGITS;
        end else begin
          phase_next       = PH_SKIP;
          negative_next    = 1'b0;
          term_next        = '0;
          running_sum_next = '0;
          res0.bad_format  = 1'b1;
          res_count        = 2'd1;
        end
      end
      PH_DIGITS: begin
        if (c_dig) begin
          term_next = term_x10 + digit;
        end else if (c_bar) begin
          running_sum_next = running_sum + signed_term;
          negative_next    = 1'b0;
          term_next        = '0;
          phase_next       = PH_SKIP;
        end else begin
          // The number ends; a terminator other than space starts the next token.
          res0.value       = running_sum + signed_term;
          res_count        = 2'd1;
          phase_next       = PH_SKIP;
          negative_next    = 1'b0;
          term_next        = '0;
          running_sum_next = '0;
          if (text_byte != CH_SPACE) begin
            if (c_sign) begin
              negative_next = (text_byte == CH_MINUS);
              phase_next    = PH_SIGNED;
            end else if (!c_ws) begin
              res1.bad_format = 1'b1;
              res_count       = 2'd2;
            end
          end
        end
      end
      default: begin
        // Skipping whitespace at the start of a term.
        phase_next = PH_SKIP;
        if (c_sign) begin
          negative_next = (text_byte == CH_MINUS);
          term_next     = '0;
          phase_next    = PH_SIGNED;
        end else if (c_dig) begin
          negative_next = 1'b0;
          term_next     = digit;
          phase_next    = PH_DIGITS;
        end else if (!c_ws) begin
          negative_next    = 1'b0;
          term_next        = '0;
          running_sum_next = '0;
          res0.bad_format  = 1'b1;
          res_count        = 2'd1;
        end
      end
    endcase
    // Mark the final result caused by this byte.
    res0.last_of_run = (res_count == 2'd1);
    res1.last_of_run = (res_count == 2'd2);
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      negative    <= 1'b0;
      term        <= '0;
      running_sum <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      negative    <= negative_next;
      term        <= term_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for signed_decimal_sum_parser: random text streams, predicted sums.
// Depends on sdsp_pkg, sdsp_text_if, sdsp_result_if and the parser RTL.
module tb;
  import sdsp_pkg::*;

  localparam int TEXT_ITEMS   = 1050;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdsp_text_if   text_ch();
  sdsp_result_if result_ch();

  signed_decimal_sum_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  // Driven copies of the block inputs, known from time zero.
  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       drv_ready = 1'b0;
  logic       rx_hold   = 1'b0;

  assign text_ch.valid     = drv_valid;
  assign text_ch.text_byte = drv_byte;
  assign result_ch.ready   = drv_ready;

  // Handshakes seen at the last rising edge, used by the falling-edge drivers.
  logic text_fire   = 1'b0;
  logic result_fire = 1'b0;

  logic [7:0]   pending_text[$];
  sdsp_result_t expected_results[$];

  int cycles       = 0;
  int bytes_taken  = 0;
  int results_seen = 0;
  int bad_seen     = 0;
  int input_stalls = 0;
  int mismatches   = 0;

  // Parser state as predicted by the testbench.
  phase_t      parse_phase = PH_SKIP;
  logic        term_neg    = 1'b0;
  logic [31:0] term_acc    = 32'd0;
  logic [31:0] sum_acc     = 32'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [31:0] signed_term();
    return term_neg ? (32'd0 - term_acc) : term_acc;
  endfunction

  function automatic void clear_number();
    parse_phase = PH_SKIP;
    term_neg    = 1'b0;
    term_acc    = 32'd0;
    sum_acc     = 32'd0;
  endfunction

  // Handles the first byte of a token; returns 1 when the byte is a format error.
  function automatic logic begin_term(input logic [7:0] c);
    if (is_space(c)) begin
      return 1'b0;
    end
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      term_neg    = (c == CH_MINUS);
      term_acc    = 32'd0;
      parse_phase = PH_SIGNED;
      return 1'b0;
    end
    if (is_digit(c)) begin
      term_neg    = 1'b0;
      term_acc    = 32'(c - CH_ZERO);
      parse_phase = PH_DIGITS;
      return 1'b0;
    end
    clear_number();
    return 1'b1;
  endfunction

  // Advances the predicted parser by one byte and queues the results it causes.
  task automatic parse_byte(input logic [7:0] c);
    sdsp_result_t caused[$];
    sdsp_result_t r;
    logic [31:0]  total;
    r = '0;
    case (parse_phase)
      PH_SIGNED: begin
        if (is_digit(c)) begin
          term_acc    = 32'(c - CH_ZERO);
          parse_phase = PH_DIGITS;
        end else begin
          clear_number();
          r.bad_format = 1'b1;
          caused.push_back(r);
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          term_acc = term_acc * 32'd10 + 32'(c - CH_ZERO);
        end else if (c == CH_BAR) begin
          sum_acc     = sum_acc + signed_term();
          term_neg    = 1'b0;
          term_acc    = 32'd0;
          parse_phase = PH_SKIP;
        end else begin
          total = sum_acc + signed_term();
          clear_number();
          r.value = total;
          caused.push_back(r);
          // A terminator other than space also starts the next token.
          if ((c != CH_SPACE) && begin_term(c)) begin
            r = '0;
            r.bad_format = 1'b1;
            caused.push_back(r);
          end
        end
      end
      default: begin
        parse_phase = PH_SKIP;
        if (begin_term(c)) begin
          r.bad_format = 1'b1;
          caused.push_back(r);
        end
      end
    endcase
    if (caused.size() > 0) begin
      caused[caused.size() - 1].last_of_run = 1'b1;
    end
    foreach (caused[i]) begin
      expected_results.push_back(caused[i]);
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s", cycles, what);
    end
  endtask

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Rising edge: sample handshakes, check results, feed the predictor, watch the clock.
  always @(posedge clk) begin
    sdsp_result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      text_fire   <= text_ch.valid && text_ch.ready;
      result_fire <= result_ch.valid && result_ch.ready;
      if (!rst) begin
        if (result_ch.valid && result_ch.ready) begin
          results_seen++;
          if (result_ch.bad_format) begin
            bad_seen++;
          end
          if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result value %0d bad_format %0b",
                                    result_ch.value, result_ch.bad_format));
          end else begin
            want = expected_results.pop_front();
            if (result_ch.value !== want.value) begin
              flag_mismatch($sformatf("result %0d value %0d, expected %0d",
                                      results_seen, result_ch.value, want.value));
            end
            if (result_ch.bad_format !== want.bad_format) begin
              flag_mismatch($sformatf("result %0d bad_format %b, expected %b",
                                      results_seen, result_ch.bad_format, want.bad_format));
            end
            if (result_ch.last_of_run !== want.last_of_run) begin
              flag_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                      results_seen, result_ch.last_of_run, want.last_of_run));
            end
          end
        end
        if (text_ch.valid && !text_ch.ready && rx_hold) begin
          input_stalls++;
        end
        if (text_ch.valid && text_ch.ready) begin
          parse_byte(text_ch.text_byte);
          bytes_taken++;
        end
      end
    end
  end

  // Text driver: one byte per item from the pending queue, with a random gap after each.
  int send_gap   = 0;
  bit send_burst = 1'b0;

  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = drv_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!drv_valid || text_fire) begin
      if (send_gap > 0) begin
        nxt_valid = 1'b0;
        send_gap--;
      end else if (pending_text.size() > 0) begin
        drv_byte  <= pending_text.pop_front();
        nxt_valid = 1'b1;
        send_gap  = draw_gap(send_burst);
        if ($urandom_range(0, 49) == 0) begin
          send_burst = !send_burst;
        end
      end else begin
        nxt_valid = 1'b0;
      end
    end
    drv_valid <= nxt_valid;
  end

  // Result receiver: a random wait after each accepted item, plus the long hold-off.
  int take_wait   = 0;
  bit take_burst  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      drv_ready <= 1'b0;
    end else begin
      if (result_fire) begin
        take_wait = draw_gap(take_burst);
        if ($urandom_range(0, 29) == 0) begin
          take_burst = !take_burst;
        end
      end
      if (rx_hold) begin
        drv_ready <= 1'b0;
      end else if (take_wait > 0) begin
        drv_ready <= 1'b0;
        take_wait--;
      end else begin
        drv_ready <= 1'b1;
      end
    end
  end

  // Long receiver stall once the stream is under way, so the output queue fills.
  initial begin
    wait (bytes_taken >= HOLD_AFTER);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_text(input string s);
    foreach (s[i]) begin
      pending_text.push_back(8'(s[i]));
    end
  endtask

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  // Byte that ends a number: mostly space, else whitespace or anything but a digit or bar.
  function automatic logic [7:0] pick_stop();
    int          r;
    logic [7:0]  c;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return CH_SPACE;
    end
    if (r < 7) begin
      return pick_space();
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_digit(c) || (c == CH_BAR));
    return c;
  endfunction

  // A well-formed number: one or more chained signed terms and a terminator.
  task automatic push_number();
    int terms;
    int ndig;
    int sign;
    terms = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    for (int t = 0; t < terms; t++) begin
      repeat ($urandom_range(0, 2)) pending_text.push_back(pick_space());
      sign = $urandom_range(0, 2);
      if (sign == 1) begin
        pending_text.push_back(CH_PLUS);
      end else if (sign == 2) begin
        pending_text.push_back(CH_MINUS);
      end
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
      repeat (ndig) pending_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if (t < terms - 1) begin
        pending_text.push_back(CH_BAR);
      end
    end
    pending_text.push_back(pick_stop());
  endtask

  // Malformed input: raw bytes, a sign with no digit, or a chain followed by junk.
  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: begin
        pending_text.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        pending_text.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
        pending_text.push_back(pick_stop());
      end
      default: begin
        pending_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        pending_text.push_back(CH_BAR);
        pending_text.push_back(pick_stop());
      end
    endcase
  endtask

  initial begin
    int start_len;
    // Directed: signs, whitespace terminators, chains with spaces and signs,
    // negative zero ended by a bad byte, bad byte after a sign, extreme bytes
    // while skipping, a chain discarded by junk, and a sign ending a number.
    push_text("+7 -12\t9| -3|+4 -0x+q");
    pending_text.push_back(8'hFF);
    pending_text.push_back(8'h00);
    push_text("5|?8-1 ");
    start_len = pending_text.size();
    while (pending_text.size() < start_len + TEXT_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        push_number();
      end else begin
        push_noise();
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_text.size() != 0 || drv_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d text bytes into %0d results, %0d of them format errors.",
             bytes_taken, results_seen, bad_seen);
    $display("Receiver held off for %0d cycles; input stalled %0d cycles meanwhile.",
             HOLD_CYCLES, input_stalls);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
